FILE: sv/generation_handle_table_macros.svh
// ----------------------------------------------------------------------------
// Generation handle table: assertion macros
// Concurrent assertion wrappers shared by the modules of the handle table.
// ----------------------------------------------------------------------------
`ifndef GENERATION_HANDLE_TABLE_MACROS_SVH
`define GENERATION_HANDLE_TABLE_MACROS_SVH

`ifndef SYNTHESIS
// Checked on every rising edge outside reset.
`define GHT_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);
// Checked on every rising edge, reset included.
`define GHT_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);
`else
`define GHT_ASSERT(lbl, prop, msg)
`define GHT_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

FILE: sv/ght_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generation handle table: package
// Sizes, codes and shared types of the handle table.
// ----------------------------------------------------------------------------
package ght_pkg;

    localparam int SLOT_COUNT = 1024;
    localparam int GEN_SHIFT  = 12;

    localparam int SLOT_W   = $clog2(SLOT_COUNT);
    localparam int LINK_W   = $clog2(SLOT_COUNT + 1);
    localparam int HANDLE_W = 31;
    localparam int IDX_W    = 10;
    localparam int RUNS_W   = 32;

    localparam logic [31:0] GEN_ONE  = 32'd1 << GEN_SHIFT;
    localparam logic [31:0] GEN_MASK = ~(32'(SLOT_COUNT) - 32'd1);

    typedef logic [1:0]          t_cmd;
    typedef logic [1:0]          t_status;
    typedef logic [HANDLE_W-1:0] t_handle;
    typedef logic [IDX_W-1:0]    t_idx;
    typedef logic [RUNS_W-1:0]   t_runs;
    typedef logic [SLOT_W-1:0]   t_slot;
    typedef logic [LINK_W-1:0]   t_link;

    localparam t_cmd CMD_ALLOC  = 2'd0;
    localparam t_cmd CMD_FREE   = 2'd1;
    localparam t_cmd CMD_LOOKUP = 2'd2;
    localparam t_cmd CMD_RUN    = 2'd3;

    localparam t_status RES_OK     = 2'd0;
    localparam t_status RES_NOFREE = 2'd1;
    localparam t_status RES_BAD    = 2'd2;

    typedef struct packed {
        logic load;
        logic exec;
    } t_dp_ctl;

endpackage

FILE: sv/ght_cmd_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generation handle table: command channel
// Valid/ready channel carrying one command beat.
// ----------------------------------------------------------------------------
interface ght_cmd_if import ght_pkg::*; ();
    logic    valid;
    logic    ready;
    t_cmd    command;
    t_handle handle;
    t_handle parent_handle;
    logic    check_perm;
    t_idx    slot_index;

    modport source (output valid, command, handle, parent_handle, check_perm, slot_index,
                    input ready);
    modport sink (input valid, command, handle, parent_handle, check_perm, slot_index,
                  output ready);
endinterface

FILE: sv/ght_res_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generation handle table: result channel
// Valid/ready channel carrying one result beat.
// ----------------------------------------------------------------------------
interface ght_res_if import ght_pkg::*; ();
    logic    valid;
    logic    ready;
    t_status status;
    logic    found;
    t_idx    result_slot;
    t_handle result_handle;
    t_runs   run_total;

    modport source (output valid, status, found, result_slot, result_handle, run_total,
                    input ready);
    modport sink (input valid, status, found, result_slot, result_handle, run_total,
                  output ready);
endinterface

FILE: sv/ght_ctrl.sv
`timescale 1ns / 1ps
`include "generation_handle_table_macros.svh"
// ----------------------------------------------------------------------------
// Generation handle table: controller
// Sequences the read and update cycles and owns the result valid flag.
// ----------------------------------------------------------------------------
module ght_ctrl import ght_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    output logic    o_out_valid,
    input  logic    i_out_ready,
    output t_dp_ctl o_ctl
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_EXEC = 1'b1;

    logic r_state, n_state;
    logic r_out_valid, n_out_valid;

    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_ctl.load  = i_in_valid && o_in_ready;
    assign o_ctl.exec  = (r_state == ST_EXEC) && (!r_out_valid || i_out_ready);

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (o_ctl.load) begin
                    n_state = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (o_ctl.exec) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (o_ctl.exec) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    `GHT_ASSERT_ALWAYS(a_rst_clears_valid, !i_rst_n |=> !r_out_valid, "reset left a result beat")
    `GHT_ASSERT(a_exec_gives_beat, o_ctl.exec |=> r_out_valid, "update did not present a beat")

endmodule

FILE: sv/ght_dp.sv
`timescale 1ns / 1ps
`include "generation_handle_table_macros.svh"
// ----------------------------------------------------------------------------
// Generation handle table: datapath
// Slot memories, free list head, fill count, current slot and result register.
// ----------------------------------------------------------------------------
module ght_dp import ght_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_dp_ctl i_ctl,
    input  t_cmd    i_command,
    input  t_handle i_handle,
    input  t_handle i_parent_handle,
    input  logic    i_check_perm,
    input  t_idx    i_slot_index,
    output t_status o_status,
    output logic    o_found,
    output t_idx    o_result_slot,
    output t_handle o_result_handle,
    output t_runs   o_run_total
);

    // Slots at or above the fill count have never been allocated and read as
    // their reset contents. The running slot is always the current one, so the
    // status memory only records whether a slot is in use.
    logic    m_busy   [SLOT_COUNT];
    t_handle m_handle [SLOT_COUNT];
    t_handle m_parent [SLOT_COUNT];
    t_link   m_next   [SLOT_COUNT];
    t_runs   m_runs   [SLOT_COUNT];

    t_cmd    r_cmd;
    t_handle r_hnd;
    t_handle r_parent;
    logic    r_perm;
    t_idx    r_idx;
    t_slot   r_addr;
    logic    r_fresh;

    logic    r_busy_a;
    t_handle r_hnd_a;
    t_handle r_par_a;
    t_link   r_next_a;
    t_runs   r_runs_a;
    t_handle r_hnd_b;

    t_link   r_free_head, n_free_head;
    t_link   r_fill, n_fill;
    t_slot   r_cur_slot, n_cur_slot;
    logic    r_cur_valid, n_cur_valid;

    t_status r_status, n_status;
    logic    r_found, n_found;
    t_idx    r_res_slot, n_res_slot;
    t_handle r_res_handle, n_res_handle;
    t_runs   r_run_total, n_run_total;

    t_slot   w_rd_addr;
    logic    w_rd_fresh;
    logic    w_busy_a;
    t_handle w_hnd_a;
    t_link   w_next_a;
    logic    w_head_ok;
    logic    w_idx_ok;
    logic [31:0] w_gen_sum;
    logic [31:0] w_gen_masked;
    logic [31:0] w_gen;
    t_handle w_new_handle;
    logic    w_wr_busy, w_busy_val;
    logic    w_wr_alloc;
    logic    w_wr_next;
    logic    w_wr_runs;
    t_runs   w_runs_val;
    logic    w_alloc_fresh;

    always_comb begin
        case (i_command)
            CMD_ALLOC:  w_rd_addr = t_slot'(r_free_head);
            CMD_LOOKUP: w_rd_addr = t_slot'(i_handle);
            default:    w_rd_addr = t_slot'(i_slot_index);
        endcase
    end

    assign w_rd_fresh = (t_link'(w_rd_addr) >= r_fill);

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_cmd    <= i_command;
            r_hnd    <= i_handle;
            r_parent <= i_parent_handle;
            r_perm   <= i_check_perm;
            r_idx    <= i_slot_index;
            r_addr   <= w_rd_addr;
            r_fresh  <= w_rd_fresh;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.exec && w_wr_busy) begin
            m_busy[r_addr] <= w_busy_val;
        end
        if (i_ctl.load) begin
            r_busy_a <= m_busy[w_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.exec && w_wr_alloc) begin
            m_handle[r_addr] <= w_new_handle;
        end
        if (i_ctl.load) begin
            r_hnd_a <= m_handle[w_rd_addr];
            r_hnd_b <= m_handle[r_cur_slot];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.exec && w_wr_alloc) begin
            m_parent[r_addr] <= r_parent;
        end
        if (i_ctl.load) begin
            r_par_a <= m_parent[w_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.exec && w_wr_next) begin
            m_next[r_addr] <= r_free_head;
        end
        if (i_ctl.load) begin
            r_next_a <= m_next[w_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.exec && w_wr_runs) begin
            m_runs[r_addr] <= w_runs_val;
        end
        if (i_ctl.load) begin
            r_runs_a <= m_runs[w_rd_addr];
        end
    end

    assign w_busy_a  = r_fresh ? 1'b0 : r_busy_a;
    assign w_hnd_a   = r_fresh ? '0 : r_hnd_a;
    assign w_next_a  = r_fresh ? t_link'(32'(r_addr) + 32'd1) : r_next_a;
    assign w_head_ok = (r_free_head < t_link'(SLOT_COUNT));
    assign w_idx_ok  = (32'(r_idx) < 32'(SLOT_COUNT));

    assign w_gen_sum    = 32'(w_hnd_a) + GEN_ONE;
    assign w_gen_masked = w_gen_sum & GEN_MASK;
    assign w_gen        = ((w_gen_masked == 32'd0) || w_gen_masked[31]) ? GEN_ONE : w_gen_masked;
    assign w_new_handle = w_gen[HANDLE_W-1:0] | t_handle'(r_addr);

    always_comb begin
        n_status     = RES_BAD;
        n_found      = 1'b0;
        n_res_slot   = '0;
        n_res_handle = '0;
        n_run_total  = '0;
        w_wr_busy    = 1'b0;
        w_busy_val   = 1'b0;
        w_wr_alloc   = 1'b0;
        w_wr_next    = 1'b0;
        w_wr_runs    = 1'b0;
        w_runs_val   = '0;
        n_free_head  = r_free_head;
        n_fill       = r_fill;
        n_cur_slot   = r_cur_slot;
        n_cur_valid  = r_cur_valid;
        case (r_cmd)
            CMD_ALLOC: begin
                if (!w_head_ok) begin
                    n_status = RES_NOFREE;
                end else begin
                    n_status     = RES_OK;
                    n_found      = 1'b1;
                    n_res_slot   = t_idx'(r_addr);
                    n_res_handle = w_new_handle;
                    w_wr_busy    = 1'b1;
                    w_busy_val   = 1'b1;
                    w_wr_alloc   = 1'b1;
                    w_wr_runs    = 1'b1;
                    n_free_head  = w_next_a;
                    if (r_fresh) begin
                        n_fill = t_link'(r_fill + 1'b1);
                    end
                end
            end
            CMD_FREE: begin
                if (w_idx_ok && w_busy_a) begin
                    n_status    = RES_OK;
                    w_wr_busy   = 1'b1;
                    w_wr_next   = 1'b1;
                    n_free_head = t_link'(r_addr);
                end
            end
            CMD_LOOKUP: begin
                if (r_hnd == '0) begin
                    n_status = RES_OK;
                    if (r_cur_valid) begin
                        n_found      = 1'b1;
                        n_res_slot   = t_idx'(r_cur_slot);
                        n_res_handle = r_hnd_b;
                    end
                end else if (w_busy_a && (w_hnd_a == r_hnd) &&
                             (!r_perm || (r_cur_valid &&
                              ((r_addr == r_cur_slot) || (r_par_a == r_hnd_b))))) begin
                    n_status     = RES_OK;
                    n_found      = 1'b1;
                    n_res_slot   = t_idx'(r_addr);
                    n_res_handle = w_hnd_a;
                end
            end
            CMD_RUN: begin
                if (w_idx_ok && w_busy_a) begin
                    n_status     = RES_OK;
                    n_found      = 1'b1;
                    n_res_slot   = t_idx'(r_addr);
                    n_res_handle = w_hnd_a;
                    n_run_total  = r_runs_a + 1'b1;
                    w_wr_runs    = 1'b1;
                    w_runs_val   = r_runs_a + 1'b1;
                    n_cur_slot   = r_addr;
                    n_cur_valid  = 1'b1;
                end
            end
            default: begin
                n_status = RES_BAD;
            end
        endcase
    end

    assign w_alloc_fresh = i_ctl.exec && (r_cmd == CMD_ALLOC) && w_head_ok && r_fresh;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_free_head <= '0;
            r_fill      <= '0;
            r_cur_slot  <= '0;
            r_cur_valid <= 1'b0;
        end else if (i_ctl.exec) begin
            r_free_head <= n_free_head;
            r_fill      <= n_fill;
            r_cur_slot  <= n_cur_slot;
            r_cur_valid <= n_cur_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.exec) begin
            r_status     <= n_status;
            r_found      <= n_found;
            r_res_slot   <= n_res_slot;
            r_res_handle <= n_res_handle;
            r_run_total  <= n_run_total;
        end
    end

    assign o_status        = r_status;
    assign o_found         = r_found;
    assign o_result_slot   = r_res_slot;
    assign o_result_handle = r_res_handle;
    assign o_run_total     = r_run_total;

    `GHT_ASSERT(a_fill_bound, r_fill <= t_link'(SLOT_COUNT), "fill count beyond table")
    `GHT_ASSERT(a_fill_step, w_alloc_fresh |=> (r_fill == t_link'($past(r_fill) + 1'b1)), "fill count missed a step")

endmodule

FILE: sv/generation_handle_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generation handle table
// Slot table with generation-tagged handles and a last-in first-out free list.
// ----------------------------------------------------------------------------
// Usage:
// Commands arrive as beats on i_cmd (allocate, free, look up, run) and each
// gives exactly one beat on o_res with status, found flag, slot, handle and
// run count. A command is taken when its slot entries are read from the
// block memories, and carried out in the update step, when the memories,
// free list head and current slot are updated and the result register is
// loaded. The block takes no new command until the last one is carried out,
// since the synchronous memory read is followed by an update of the same
// entries.
// A command may be accepted while the previous result still waits; if the
// receiver stalls, the update of that command waits until the result
// register is free, and i_cmd.ready stays low meanwhile.
// After reset every slot is free and the list runs from slot 0 upward. No
// clearing pass is needed: a fill count marks the slots never allocated,
// which read as their reset contents, so commands are taken at once.
// ----------------------------------------------------------------------------
module generation_handle_table import ght_pkg::*; (
    input logic       i_clk,
    input logic       i_rst_n,
    ght_cmd_if.sink   i_cmd,
    ght_res_if.source o_res
);

    t_dp_ctl w_ctl;

    ght_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_cmd.valid),
        .o_in_ready  (i_cmd.ready),
        .o_out_valid (o_res.valid),
        .i_out_ready (o_res.ready),
        .o_ctl       (w_ctl)
    );

    ght_dp u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_ctl           (w_ctl),
        .i_command       (i_cmd.command),
        .i_handle        (i_cmd.handle),
        .i_parent_handle (i_cmd.parent_handle),
        .i_check_perm    (i_cmd.check_perm),
        .i_slot_index    (i_cmd.slot_index),
        .o_status        (o_res.status),
        .o_found         (o_res.found),
        .o_result_slot   (o_res.result_slot),
        .o_result_handle (o_res.result_handle),
        .o_run_total     (o_res.run_total)
    );

endmodule
